@@ rtl/necir_pkg.sv @@
// ----------------------------------------------------------------------------
// necir_pkg
// Shared types and constants of the NEC infrared frame decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

    // Every duration is an unsigned count of 1 us ticks.
    localparam int TICK_W    = 15;
    localparam int CODE_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPACE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd6;

    // Register values after reset.
    localparam logic [TICK_W-1:0] RST_TOLERANCE    = 15'd200;
    localparam logic [TICK_W-1:0] RST_LEADER_MARK  = 15'd9000;
    localparam logic [TICK_W-1:0] RST_LEADER_SPACE = 15'd4500;
    localparam logic [TICK_W-1:0] RST_REPEAT_SPACE = 15'd2250;
    localparam logic [TICK_W-1:0] RST_BIT_MARK     = 15'd560;
    localparam logic [TICK_W-1:0] RST_ONE_SPACE    = 15'd1690;
    localparam logic [TICK_W-1:0] RST_ZERO_SPACE   = 15'd560;

    localparam logic [CODE_W-1:0] REPEAT_CODE = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        STATUS_REJECT = 2'd0,
        STATUS_DATA   = 2'd1,
        STATUS_REPEAT = 2'd2
    } t_status;

    // Window hits of one symbol against every expected duration.
    typedef struct packed {
        logic leader_mark;
        logic repeat_space;
        logic leader_space;
        logic bit_mark;
        logic one_space;
        logic zero_space;
    } t_match;

    typedef struct packed {
        t_status            status;
        logic [CODE_W-1:0]  code;
    } t_result;

endpackage

@@ rtl/necir_window.sv @@
// ----------------------------------------------------------------------------
// necir_window
// Checks that a duration lies within expected +/- tolerance, the lower
// bound held at zero.
// ----------------------------------------------------------------------------
module necir_window (
    input  logic [necir_pkg::TICK_W-1:0] i_ticks,
    input  logic [necir_pkg::TICK_W-1:0] i_expect,
    input  logic [necir_pkg::TICK_W-1:0] i_tol,
    output logic                         o_hit
);

    logic [necir_pkg::TICK_W-1:0] w_low;
    logic [necir_pkg::TICK_W:0]   w_high;

    always_comb begin
        w_low  = (i_expect > i_tol) ? (i_expect - i_tol) : '0;
        w_high = {1'b0, i_expect} + {1'b0, i_tol};
        o_hit  = (i_ticks >= w_low) && ({1'b0, i_ticks} <= w_high);
    end

endmodule

@@ rtl/necir_frame.sv @@
// ----------------------------------------------------------------------------
// necir_frame
// Frame state: symbol count, collected bits and the failure and repeat
// flags. Builds the result that a last symbol would give.
// ----------------------------------------------------------------------------
module necir_frame #(
    parameter int CODE_BITS   = 32,
    parameter int MIN_SYMBOLS = 34
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_last,
    input  necir_pkg::t_match   i_match,
    output necir_pkg::t_result  o_result
);

    localparam int SAT_COUNT = (MIN_SYMBOLS > CODE_BITS + 1) ? MIN_SYMBOLS : CODE_BITS + 1;
    localparam int IDX_W     = $clog2(SAT_COUNT + 1);

    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [CODE_BITS-1:0] r_shift, n_shift;
    logic                 r_fail, n_fail;
    logic                 r_rep, n_rep;

    always_comb begin
        n_fail  = r_fail;
        n_rep   = r_rep;
        n_shift = r_shift;

        if (!r_fail && !r_rep) begin
            if (r_idx == '0) begin
                if (!i_match.leader_mark) begin
                    n_fail = 1'b1;
                end else if (i_match.repeat_space) begin
                    n_rep = 1'b1;
                end else if (!i_match.leader_space) begin
                    n_fail = 1'b1;
                end
            end else if (r_idx <= IDX_W'(CODE_BITS)) begin
                if (!i_match.bit_mark) begin
                    n_fail = 1'b1;
                end else if (i_match.one_space) begin
                    for (int j = 0; j < CODE_BITS; j++) begin
                        if (r_idx == IDX_W'(j + 1)) begin
                            n_shift[j] = 1'b1;
                        end
                    end
                end else if (!i_match.zero_space) begin
                    n_fail = 1'b1;
                end
            end
        end

        n_idx = (r_idx < IDX_W'(SAT_COUNT)) ? r_idx + IDX_W'(1) : r_idx;

        o_result.code = '0;
        if (n_idx < IDX_W'(MIN_SYMBOLS) || n_fail) begin
            o_result.status = necir_pkg::STATUS_REJECT;
        end else if (n_rep) begin
            o_result.status = necir_pkg::STATUS_REPEAT;
            o_result.code   = necir_pkg::REPEAT_CODE;
        end else begin
            o_result.status = necir_pkg::STATUS_DATA;
            o_result.code[CODE_BITS-1:0] = n_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_shift <= '0;
            r_fail  <= 1'b0;
            r_rep   <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_idx   <= '0;
                r_shift <= '0;
                r_fail  <= 1'b0;
                r_rep   <= 1'b0;
            end else begin
                r_idx   <= n_idx;
                r_shift <= n_shift;
                r_fail  <= n_fail;
                r_rep   <= n_rep;
            end
        end
    end

    // A frame never carries both flags from the leader symbol.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fail && r_rep))
        else $error("frame failed and repeat flags both set");

    // Bits are only collected while the frame is a data frame that has not failed.
    a_shift_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_last && (r_fail || r_rep)) |=> $stable(r_shift))
        else $error("data bits changed after the frame stopped collecting");

    // The count restarts after every last symbol.
    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_idx == '0))
        else $error("symbol count not cleared after a frame ended");

endmodule

@@ rtl/nec_ir_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// Decodes NEC infrared frames from a stream of mark/space symbol durations.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the slave stream is one received IR symbol: tdata carries
// the mark and space durations in 1 us ticks, and tlast marks the final
// symbol of a frame. Only a last symbol produces a request on the master
// stream: tuser gives the status (rejected, data code or repeat code) and
// tdata the 32-bit code, LSB first as received.
// The seven timing registers are written over the plain write port while
// the decoder is idle; they reset to the standard NEC timing.
// A symbol is captured in an input register, then the window compares and
// state update move it on, and a last symbol's result is registered in the
// output register. One symbol is taken every cycle unless a last symbol waits.
// When the receiver stalls, the finished result waits in the output
// register; symbols that are not last keep flowing through, and the input
// stage holds only a next last symbol until the output register is free.
// Synchronous active-low reset clears the frame state, empties both stages
// and restores the register defaults.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder #(
    parameter int CODE_BITS   = 32,
    parameter int MIN_SYMBOLS = 34
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_wr_en,
    input  logic [necir_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [necir_pkg::TICK_W-1:0]    i_cfg_data,
    // Symbol input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [14:0] mark_ticks, [29:15] space_ticks
    input  logic        s_axis_tlast,   // last_symbol
    // Result output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] code
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int TW = necir_pkg::TICK_W;

    // Timing registers.
    logic [TW-1:0] r_tol, r_leader_mark, r_leader_space, r_repeat_space;
    logic [TW-1:0] r_bit_mark, r_one_space, r_zero_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol          <= necir_pkg::RST_TOLERANCE;
            r_leader_mark  <= necir_pkg::RST_LEADER_MARK;
            r_leader_space <= necir_pkg::RST_LEADER_SPACE;
            r_repeat_space <= necir_pkg::RST_REPEAT_SPACE;
            r_bit_mark     <= necir_pkg::RST_BIT_MARK;
            r_one_space    <= necir_pkg::RST_ONE_SPACE;
            r_zero_space   <= necir_pkg::RST_ZERO_SPACE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                necir_pkg::REG_TOLERANCE:    r_tol          <= i_cfg_data;
                necir_pkg::REG_LEADER_MARK:  r_leader_mark  <= i_cfg_data;
                necir_pkg::REG_LEADER_SPACE: r_leader_space <= i_cfg_data;
                necir_pkg::REG_REPEAT_SPACE: r_repeat_space <= i_cfg_data;
                necir_pkg::REG_BIT_MARK:     r_bit_mark     <= i_cfg_data;
                necir_pkg::REG_ONE_SPACE:    r_one_space    <= i_cfg_data;
                necir_pkg::REG_ZERO_SPACE:   r_zero_space   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage.
    logic          r_in_valid;
    logic [TW-1:0] r_mark, r_space;
    logic          r_in_last;

    // Output stage.
    logic               r_out_valid;
    necir_pkg::t_result r_out;

    logic w_out_free;
    logic w_advance;

    // A symbol that is not last leaves the input stage regardless of the
    // output; a last symbol needs the output register to be free.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && (!r_in_last || w_out_free);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_mark    <= s_axis_tdata[TW-1:0];
            r_space   <= s_axis_tdata[2*TW-1:TW];
            r_in_last <= s_axis_tlast;
        end
    end

    // Window compares for the symbol in the input stage.
    necir_pkg::t_match w_match;

    necir_window u_win_leader_mark (
        .i_ticks(r_mark),  .i_expect(r_leader_mark),  .i_tol(r_tol),
        .o_hit(w_match.leader_mark));
    necir_window u_win_repeat_space (
        .i_ticks(r_space), .i_expect(r_repeat_space), .i_tol(r_tol),
        .o_hit(w_match.repeat_space));
    necir_window u_win_leader_space (
        .i_ticks(r_space), .i_expect(r_leader_space), .i_tol(r_tol),
        .o_hit(w_match.leader_space));
    necir_window u_win_bit_mark (
        .i_ticks(r_mark),  .i_expect(r_bit_mark),     .i_tol(r_tol),
        .o_hit(w_match.bit_mark));
    necir_window u_win_one_space (
        .i_ticks(r_space), .i_expect(r_one_space),    .i_tol(r_tol),
        .o_hit(w_match.one_space));
    necir_window u_win_zero_space (
        .i_ticks(r_space), .i_expect(r_zero_space),   .i_tol(r_tol),
        .o_hit(w_match.zero_space));

    necir_pkg::t_result w_result;

    necir_frame #(
        .CODE_BITS  (CODE_BITS),
        .MIN_SYMBOLS(MIN_SYMBOLS)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_last  (r_in_last),
        .i_match (w_match),
        .o_result(w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.code;
    assign m_axis_tuser  = r_out.status;

    // A rejected frame always reports a zero code.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == necir_pkg::STATUS_REJECT) |-> (r_out.code == '0))
        else $error("rejected frame with nonzero code");

    // A repeat frame always reports the all-ones code.
    a_repeat_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == necir_pkg::STATUS_REPEAT)
            |-> (r_out.code == necir_pkg::REPEAT_CODE))
        else $error("repeat frame without the all-ones code");

    // A last symbol never overwrites a result the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !(w_advance && r_in_last))
        else $error("pending result overwritten");

    // A held symbol stays in the input stage until it moves on.
    a_input_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("input symbol lost while waiting");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the NEC infrared frame decoder. Symbols are streamed
// in phases under different timing settings; a built-in decoder model predicts
// every frame result and the monitor compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW             = necir_pkg::TICK_W;
    localparam int IW             = necir_pkg::CFG_IDX_W;
    localparam int CODE_BITS      = 32;
    localparam int MIN_SYMBOLS    = 34;
    // The symbol count stops at the larger of MIN_SYMBOLS and CODE_BITS + 1.
    localparam int SYM_SAT        = (MIN_SYMBOLS > CODE_BITS + 1) ? MIN_SYMBOLS
                                                                  : CODE_BITS + 1;
    localparam int TICK_MAX       = 32767;
    localparam int PHASES         = 8;
    localparam int PHASE_SYMBOLS  = 165;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;

    // Index 7 decodes to no register, so a write there must be dropped.
    localparam logic [IW-1:0] REG_UNUSED = 3'd7;

    typedef enum {
        KIND_DATA,
        KIND_REPEAT,
        KIND_SHORT_REPEAT,
        KIND_BROKEN,
        KIND_TRUNCATED,
        KIND_NOISE
    } t_frame_kind;

    typedef struct {
        logic [TW-1:0] mark;
        logic [TW-1:0] space;
        logic          last;
    } t_symbol;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic          i_cfg_wr_en = 1'b0;
    logic [IW-1:0] i_cfg_index = '0;
    logic [TW-1:0] i_cfg_data  = '0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Symbols waiting for the driver, and decoded frames waiting for the monitor.
    t_symbol            symbols_to_send [$];
    necir_pkg::t_result codes_due [$];

    // Timing registers as the decoder should hold them, indexed by REG_* names.
    logic [TW-1:0] timing_reg [0:6];

    // Frame state of the model decoder.
    int                           sym_count    = 0;
    logic [necir_pkg::CODE_W-1:0] bits_acc     = '0;
    bit                           frame_bad    = 1'b0;
    bit                           repeat_frame = 1'b0;

    // Idle knobs, changed only between phases.
    int tx_gap_max   = 0;
    int rx_stall_pct = 0;
    int rx_stall_max = 1;

    int error_count = 0;
    int idle_cycles = 0;

    nec_ir_frame_decoder #(
        .CODE_BITS   (CODE_BITS),
        .MIN_SYMBOLS (MIN_SYMBOLS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [14:0] mark_ticks, [29:15] space_ticks
        .s_axis_tlast  (s_axis_tlast),   // last_symbol
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] code
        .m_axis_tuser  (m_axis_tuser)    // [1:0] status
    );

    always #6 i_clk = ~i_clk;

    initial begin
        timing_reg[necir_pkg::REG_TOLERANCE]    = necir_pkg::RST_TOLERANCE;
        timing_reg[necir_pkg::REG_LEADER_MARK]  = necir_pkg::RST_LEADER_MARK;
        timing_reg[necir_pkg::REG_LEADER_SPACE] = necir_pkg::RST_LEADER_SPACE;
        timing_reg[necir_pkg::REG_REPEAT_SPACE] = necir_pkg::RST_REPEAT_SPACE;
        timing_reg[necir_pkg::REG_BIT_MARK]     = necir_pkg::RST_BIT_MARK;
        timing_reg[necir_pkg::REG_ONE_SPACE]    = necir_pkg::RST_ONE_SPACE;
        timing_reg[necir_pkg::REG_ZERO_SPACE]   = necir_pkg::RST_ZERO_SPACE;
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] ERROR %s", $realtime, msg);
        end
    endtask

    // A duration hits when it lies within nominal +/- tolerance. The lower
    // bound stops at zero; the upper bound may pass the 15-bit range.
    function automatic bit in_window(input int ticks, input int nominal);
        int tol;
        int lo;
        tol = timing_reg[necir_pkg::REG_TOLERANCE];
        lo  = (nominal > tol) ? nominal - tol : 0;
        return (ticks >= lo) && (ticks <= nominal + tol);
    endfunction

    // Model of the decoder: advances the frame state by one accepted symbol
    // and, on the last symbol of a frame, queues the result it must give.
    task automatic decode_symbol(input logic [TW-1:0] mark,
                                 input logic [TW-1:0] space,
                                 input logic last);
        necir_pkg::t_result res;
        if (!frame_bad && !repeat_frame) begin
            if (sym_count == 0) begin
                // Leader: the repeat window wins when both spaces match.
                if (!in_window(mark, timing_reg[necir_pkg::REG_LEADER_MARK])) begin
                    frame_bad = 1'b1;
                end else if (in_window(space, timing_reg[necir_pkg::REG_REPEAT_SPACE])) begin
                    repeat_frame = 1'b1;
                end else if (!in_window(space, timing_reg[necir_pkg::REG_LEADER_SPACE])) begin
                    frame_bad = 1'b1;
                end
            end else if (sym_count <= CODE_BITS) begin
                // Data bit: a one is preferred when both spaces match.
                if (!in_window(mark, timing_reg[necir_pkg::REG_BIT_MARK])) begin
                    frame_bad = 1'b1;
                end else if (in_window(space, timing_reg[necir_pkg::REG_ONE_SPACE])) begin
                    bits_acc[sym_count-1] = 1'b1;
                end else if (!in_window(space, timing_reg[necir_pkg::REG_ZERO_SPACE])) begin
                    frame_bad = 1'b1;
                end
            end
        end
        if (sym_count < SYM_SAT) begin
            sym_count++;
        end
        if (last) begin
            // Short frames are rejected even when the leader said repeat.
            if (sym_count < MIN_SYMBOLS || frame_bad) begin
                res.status = necir_pkg::STATUS_REJECT;
                res.code   = '0;
            end else if (repeat_frame) begin
                res.status = necir_pkg::STATUS_REPEAT;
                res.code   = necir_pkg::REPEAT_CODE;
            end else begin
                res.status = necir_pkg::STATUS_DATA;
                res.code   = bits_acc;
            end
            codes_due.push_back(res);
            sym_count    = 0;
            bits_acc     = '0;
            frame_bad    = 1'b0;
            repeat_frame = 1'b0;
        end
    endtask

    // Picks a duration inside the window around nominal, or just outside it.
    // Misses that clamp back into range are fine: the model decides anyway.
    function automatic logic [TW-1:0] near(input int nominal, input bit hit);
        int tol;
        int lo;
        int hi;
        int v;
        tol = timing_reg[necir_pkg::REG_TOLERANCE];
        lo  = (nominal > tol) ? nominal - tol : 0;
        hi  = nominal + tol;
        if (hi > TICK_MAX) begin
            hi = TICK_MAX;
        end
        if (hit) begin
            case ($urandom_range(3))
                0:       v = lo;
                1:       v = hi;
                2:       v = nominal;
                default: v = $urandom_range(hi, lo);
            endcase
        end else begin
            case ($urandom_range(2))
                0:       v = lo - 1;
                1:       v = nominal + tol + 1;
                default: v = $urandom_range(TICK_MAX, 0);
            endcase
        end
        if (v < 0) begin
            v = 0;
        end else if (v > TICK_MAX) begin
            v = TICK_MAX;
        end
        return v[TW-1:0];
    endfunction

    function automatic void push_symbol(input int mark, input int space, input bit last);
        t_symbol sym;
        sym.mark  = mark[TW-1:0];
        sym.space = space[TW-1:0];
        sym.last  = last;
        symbols_to_send.push_back(sym);
    endfunction

    // Queues one frame of the given kind and returns its symbol count.
    function automatic int queue_frame(input t_frame_kind kind);
        int len;
        int fault;
        bit miss_mark;
        bit hit_mark;
        bit hit_space;
        bit one;
        int mark;
        int space;
        case (kind)
            KIND_NOISE:        len = $urandom_range(6, 1);
            KIND_SHORT_REPEAT: len = 2;
            KIND_TRUNCATED:    len = $urandom_range(MIN_SYMBOLS - 1, 1);
            default: begin
                len = ($urandom_range(3) == 0) ? $urandom_range(40, MIN_SYMBOLS)
                                               : MIN_SYMBOLS;
            end
        endcase
        fault     = (kind == KIND_BROKEN) ? $urandom_range(CODE_BITS, 0) : -1;
        miss_mark = 1'($urandom_range(1));
        for (int i = 0; i < len; i++) begin
            hit_mark  = !(i == fault && miss_mark);
            hit_space = !(i == fault && !miss_mark);
            if (kind == KIND_NOISE) begin
                mark  = $urandom_range(TICK_MAX, 0);
                space = $urandom_range(TICK_MAX, 0);
            end else if (i == 0) begin
                mark = near(timing_reg[necir_pkg::REG_LEADER_MARK], hit_mark);
                if (kind == KIND_REPEAT || kind == KIND_SHORT_REPEAT) begin
                    space = near(timing_reg[necir_pkg::REG_REPEAT_SPACE], hit_space);
                end else begin
                    space = near(timing_reg[necir_pkg::REG_LEADER_SPACE], hit_space);
                end
            end else if (kind == KIND_REPEAT || kind == KIND_SHORT_REPEAT) begin
                // Nothing after a repeat leader is checked.
                mark  = near(timing_reg[necir_pkg::REG_BIT_MARK], 1'($urandom_range(1)));
                space = $urandom_range(TICK_MAX, 0);
            end else if (i <= CODE_BITS) begin
                one   = 1'($urandom_range(1));
                mark  = near(timing_reg[necir_pkg::REG_BIT_MARK], hit_mark);
                space = near(one ? timing_reg[necir_pkg::REG_ONE_SPACE]
                                 : timing_reg[necir_pkg::REG_ZERO_SPACE],
                             hit_space);
            end else begin
                mark  = near(timing_reg[necir_pkg::REG_BIT_MARK], 1'b1);
                space = $urandom_range(TICK_MAX, 0);
            end
            push_symbol(mark, space, i == len - 1);
        end
        return len;
    endfunction

    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 40) begin
            return KIND_DATA;
        end else if (r < 55) begin
            return KIND_REPEAT;
        end else if (r < 65) begin
            return KIND_SHORT_REPEAT;
        end else if (r < 80) begin
            return KIND_BROKEN;
        end else if (r < 90) begin
            return KIND_TRUNCATED;
        end
        return KIND_NOISE;
    endfunction

    // One register write per clock; the model copy changes with it. Symbols
    // never flow during a write, so the order against the driver is moot.
    task automatic write_timing(input logic [IW-1:0] idx,
                                input logic [TW-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        if (idx <= necir_pkg::REG_ZERO_SPACE) begin
            timing_reg[idx] = value;
        end
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Blocks the sequencer until every queued symbol is in and every frame
    // result is out, then lets the pipeline settle so that any symbol that
    // produced no result has also cleared the compare stage.
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (symbols_to_send.size() != 0 || s_axis_tvalid
                   || codes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sender: takes symbols from the queue in bursts of random length with
    // random gaps in between. The model is updated on each accepted request.
    always @(posedge i_clk) begin : drive_symbols
        t_symbol sym;
        bit      taken;
        int      burst_left;
        int      gap_left;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            taken = s_axis_tvalid && s_axis_tready;
            if (taken) begin
                decode_symbol(s_axis_tdata[14:0], s_axis_tdata[29:15], s_axis_tlast);
            end
            if (!s_axis_tvalid || taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (symbols_to_send.size() > 0) begin
                    sym = symbols_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, sym.space, sym.mark};
                    s_axis_tlast  <= sym.last;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(40, 1);
                        gap_left   = (tx_gap_max > 0) ? $urandom_range(tx_gap_max, 0) : 0;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result against the oldest predicted
    // frame, and stalls in runs whose rate and length the phase chooses.
    always @(posedge i_clk) begin : check_results
        necir_pkg::t_result due;
        int                 stall_left;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (codes_due.size() == 0) begin
                    flag_error($sformatf("result %0d/%08h with no frame outstanding",
                                         m_axis_tuser, m_axis_tdata));
                end else begin
                    due = codes_due.pop_front();
                    if (m_axis_tuser !== due.status) begin
                        flag_error($sformatf("frame status %0d, expected %0d",
                                             m_axis_tuser, due.status));
                    end
                    if (m_axis_tdata !== due.code) begin
                        flag_error($sformatf("frame code %08h, expected %08h",
                                             m_axis_tdata, due.code));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(99) < rx_stall_pct) begin
                stall_left = $urandom_range(rx_stall_max, 1) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_wr_en) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Sequencer: reset once, then one phase per timing setting. Each phase
    // programs the registers while the decoder is idle, queues its frames and
    // waits for every result before the next phase may touch the registers.
    initial begin : run_phases
        int queued;
        int gap_tab   [PHASES];
        int stall_tab [PHASES];
        int len_tab   [PHASES];

        gap_tab   = '{0, 4, 8, 0, 3, 8, 2, 6};
        stall_tab = '{0, 40, 10, 25, 0, 60, 15, 30};
        len_tab   = '{1, 4, 20, 3, 1, 12, 6, 2};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < PHASES; phase++) begin
            tx_gap_max   = gap_tab[phase];
            rx_stall_pct = stall_tab[phase];
            rx_stall_max = len_tab[phase];

            case (phase)
                1: begin
                    // Zero tolerance: only exact durations match.
                    write_timing(necir_pkg::REG_TOLERANCE,    15'd0);
                    write_timing(necir_pkg::REG_LEADER_MARK,  15'd9000);
                    write_timing(necir_pkg::REG_LEADER_SPACE, 15'd4500);
                    write_timing(necir_pkg::REG_REPEAT_SPACE, 15'd2250);
                    write_timing(necir_pkg::REG_BIT_MARK,     15'd560);
                    write_timing(necir_pkg::REG_ONE_SPACE,    15'd1690);
                    write_timing(necir_pkg::REG_ZERO_SPACE,   15'd560);
                    end_writes();
                end
                2: begin
                    // Widest tolerance: every window covers the whole range,
                    // so every leader reads as repeat and every bit as one.
                    write_timing(necir_pkg::REG_TOLERANCE, 15'd32767);
                    end_writes();
                end
                3: begin
                    // Nominal values at both ends of the range.
                    write_timing(necir_pkg::REG_TOLERANCE,    15'd5);
                    write_timing(necir_pkg::REG_LEADER_MARK,  15'd32767);
                    write_timing(necir_pkg::REG_LEADER_SPACE, 15'd32767);
                    write_timing(necir_pkg::REG_REPEAT_SPACE, 15'd0);
                    write_timing(necir_pkg::REG_BIT_MARK,     15'd0);
                    write_timing(necir_pkg::REG_ONE_SPACE,    15'd32767);
                    write_timing(necir_pkg::REG_ZERO_SPACE,   15'd0);
                    end_writes();
                end
                4: begin
                    // Overlapping windows for both leader spaces and both bits.
                    write_timing(necir_pkg::REG_TOLERANCE,    15'd300);
                    write_timing(necir_pkg::REG_LEADER_MARK,  15'd9000);
                    write_timing(necir_pkg::REG_LEADER_SPACE, 15'd4500);
                    write_timing(necir_pkg::REG_REPEAT_SPACE, 15'd4400);
                    write_timing(necir_pkg::REG_BIT_MARK,     15'd560);
                    write_timing(necir_pkg::REG_ONE_SPACE,    15'd700);
                    write_timing(necir_pkg::REG_ZERO_SPACE,   15'd560);
                    end_writes();
                end
                5: begin
                    // A write to the unused index must leave every register alone.
                    write_timing(REG_UNUSED,                  15'd1234);
                    write_timing(necir_pkg::REG_TOLERANCE,    15'd50);
                    write_timing(necir_pkg::REG_REPEAT_SPACE, 15'd2250);
                    write_timing(necir_pkg::REG_ONE_SPACE,    15'd1690);
                    end_writes();
                end
                6, 7: begin
                    write_timing(necir_pkg::REG_TOLERANCE, TW'($urandom_range(1500, 0)));
                    for (int r = necir_pkg::REG_LEADER_MARK;
                         r <= necir_pkg::REG_ZERO_SPACE; r++) begin
                        write_timing(IW'(r), TW'($urandom_range(TICK_MAX, 0)));
                    end
                    end_writes();
                end
                default: begin
                    // Phase 0 runs on the values left by reset.
                end
            endcase

            // Fill the queue away from the rising edge the driver works on.
            @(negedge i_clk);
            queued = 0;
            if (phase == 0) begin
                // Single- and two-symbol frames at the field extremes.
                push_symbol(0, 0, 1'b1);
                push_symbol(TICK_MAX, TICK_MAX, 1'b1);
                push_symbol(TICK_MAX, 0, 1'b0);
                push_symbol(0, TICK_MAX, 1'b1);
                // A standard two-symbol repeat frame is too short to pass.
                push_symbol(9000, 2250, 1'b0);
                push_symbol(560, 560, 1'b1);
                // Leader at the low window edges, then at the high ones.
                push_symbol(8800, 2050, 1'b0);
                push_symbol(360, 360, 1'b1);
                push_symbol(9200, 4700, 1'b1);
                push_symbol(9200, 2450, 1'b1);
                // Leader just outside its windows.
                push_symbol(8799, 4500, 1'b1);
                push_symbol(9201, 4500, 1'b0);
                push_symbol(0, TICK_MAX, 1'b1);
                push_symbol(9000, 4299, 1'b1);
                push_symbol(9000, 2451, 1'b1);
                queued = 15;
            end
            while (queued < PHASE_SYMBOLS) begin
                queued += queue_frame(pick_kind());
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
